FILE: sv/der_sequence_content_extractor_assert.svh
// Assertion macros for the extractor modules; only dsce_queue uses them.
// Both expect clk and rst_n in scope.
`ifndef DER_SEQUENCE_CONTENT_EXTRACTOR_ASSERT_SVH
`define DER_SEQUENCE_CONTENT_EXTRACTOR_ASSERT_SVH

// Same-cycle implication.
`define DSCE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dsce: assertion failed");

// Next-cycle implication.
`define DSCE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dsce: assertion failed");

`endif

FILE: sv/dsce_pkg.sv
package dsce_pkg;

    localparam int MAX_LENGTH_BYTES = 3;
    localparam int LBL_W = $clog2(MAX_LENGTH_BYTES + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] SEQ_TAG = 8'h30;
    localparam logic [7:0] STRIP_ENABLE_RST = 8'h01;
    localparam logic [7:0] STRIP_LENGTH_RST = 8'h21;
    localparam logic [23:0] MAX24 = 24'hFF_FFFF;

    // register indexes (byte address = 4 * index)
    localparam logic REG_STRIP_ENABLE = 1'b0;
    localparam logic REG_STRIP_LENGTH = 1'b1;

    typedef enum logic [2:0] {
        PH_OUTER_TAG,
        PH_OUTER_LEN,
        PH_LONG_LEN,
        PH_ELEM_TAG,
        PH_ELEM_LEN,
        PH_ELEM_DATA
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_BAD_TAG,
        ST_MISMATCH,
        ST_BAD_FORM,
        ST_TRUNCATED
    } status_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        done_res;
        status_t     status;
        logic [23:0] out_count;
    } result_t;

endpackage

FILE: sv/dsce_parse.sv
module dsce_parse
    import dsce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        strip_enable,
    input  logic [7:0]  strip_length,
    input  logic        push_ready,
    output logic        push_valid,
    output result_t     push_item
);

    phase_t             phase_reg, phase_next;
    logic [LBL_W-1:0]   lbl_reg, lbl_next;
    logic [23:0]        decl_reg, decl_next;
    logic [24:0]        seen_reg, seen_next;
    logic [7:0]         elem_left_reg, elem_left_next;
    logic               strip_pending_reg, strip_pending_next;
    logic [23:0]        produced_reg, produced_next;
    status_t            err_reg, err_next;

    logic               accept;
    logic               emit;
    status_t            final_status;

    assign in_ready = push_ready;
    assign accept   = in_valid && push_ready;

    always_comb
    begin
        phase_next         = phase_reg;
        lbl_next           = lbl_reg;
        decl_next          = decl_reg;
        seen_next          = seen_reg;
        elem_left_next     = elem_left_reg;
        strip_pending_next = strip_pending_reg;
        produced_next      = produced_reg;
        err_next           = err_reg;
        emit               = 1'b0;

        if (err_reg == ST_OK)
        begin
            // content_seen saturates one past the 24-bit range
            if (phase_reg >= PH_ELEM_TAG && !seen_reg[24])
            begin
                seen_next = seen_reg + 25'd1;
            end
            unique case (phase_reg)
                PH_OUTER_TAG:
                begin
                    if (data_byte != SEQ_TAG)
                    begin
                        err_next = ST_BAD_TAG;
                    end
                    else
                    begin
                        phase_next = PH_OUTER_LEN;
                    end
                end
                PH_OUTER_LEN:
                begin
                    if (!data_byte[7])
                    begin
                        decl_next  = {16'd0, data_byte};
                        phase_next = PH_ELEM_TAG;
                    end
                    else if (data_byte[6:0] == 7'd0 ||
                             data_byte[6:0] > 7'(MAX_LENGTH_BYTES))
                    begin
                        err_next = ST_BAD_FORM;
                    end
                    else
                    begin
                        lbl_next   = LBL_W'(data_byte[6:0]);
                        decl_next  = 24'd0;
                        phase_next = PH_LONG_LEN;
                    end
                end
                PH_LONG_LEN:
                begin
                    if (decl_reg[23:16] != 8'd0)
                    begin
                        err_next = ST_BAD_FORM;
                    end
                    else
                    begin
                        decl_next = {decl_reg[15:0], data_byte};
                        lbl_next  = lbl_reg - LBL_W'(1);
                        if (lbl_reg == LBL_W'(1))
                        begin
                            phase_next = PH_ELEM_TAG;
                        end
                    end
                end
                PH_ELEM_TAG:
                begin
                    phase_next = PH_ELEM_LEN;
                end
                PH_ELEM_LEN:
                begin
                    elem_left_next     = data_byte;
                    strip_pending_next = strip_enable && (data_byte == strip_length) &&
                                         (data_byte != 8'd0);
                    phase_next         = (data_byte == 8'd0) ? PH_ELEM_TAG : PH_ELEM_DATA;
                end
                PH_ELEM_DATA:
                begin
                    if (!(strip_pending_reg && data_byte == 8'd0))
                    begin
                        emit = 1'b1;
                        if (produced_reg != MAX24)
                        begin
                            produced_next = produced_reg + 24'd1;
                        end
                    end
                    strip_pending_next = 1'b0;
                    elem_left_next     = elem_left_reg - 8'd1;
                    if (elem_left_reg == 8'd1)
                    begin
                        phase_next = PH_ELEM_TAG;
                    end
                end
                default:
                begin
                    phase_next = PH_OUTER_TAG;
                end
            endcase
        end
    end

    always_comb
    begin
        priority if (err_next != ST_OK)
        begin
            final_status = err_next;
        end
        else if (phase_next <= PH_LONG_LEN)
        begin
            final_status = ST_MISMATCH;
        end
        else if (seen_next != {1'b0, decl_next})
        begin
            final_status = ST_MISMATCH;
        end
        else if (phase_next != PH_ELEM_TAG)
        begin
            final_status = ST_TRUNCATED;
        end
        else
        begin
            final_status = ST_OK;
        end
    end

    always_comb
    begin
        push_valid           = accept && (emit || last_byte);
        push_item.out_byte   = emit ? data_byte : 8'd0;
        push_item.byte_valid = emit;
        push_item.done_res   = last_byte;
        push_item.status     = last_byte ? final_status : ST_OK;
        push_item.out_count  = last_byte ? produced_next : 24'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_OUTER_TAG;
            lbl_reg           <= '0;
            decl_reg          <= '0;
            seen_reg          <= '0;
            elem_left_reg     <= '0;
            strip_pending_reg <= 1'b0;
            produced_reg      <= '0;
            err_reg           <= ST_OK;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                phase_reg         <= PH_OUTER_TAG;
                lbl_reg           <= '0;
                decl_reg          <= '0;
                seen_reg          <= '0;
                elem_left_reg     <= '0;
                strip_pending_reg <= 1'b0;
                produced_reg      <= '0;
                err_reg           <= ST_OK;
            end
            else
            begin
                phase_reg         <= phase_next;
                lbl_reg           <= lbl_next;
                decl_reg          <= decl_next;
                seen_reg          <= seen_next;
                elem_left_reg     <= elem_left_next;
                strip_pending_reg <= strip_pending_next;
                produced_reg      <= produced_next;
                err_reg           <= err_next;
            end
        end
    end

endmodule

FILE: sv/dsce_queue.sv
`include "der_sequence_content_extractor_assert.svh"

module dsce_queue
    import dsce_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_valid,
    output logic    push_ready,
    input  result_t push_item,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_item
);

    result_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]    count_reg, count_next;
    logic                 do_push;
    logic                 do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign out_valid  = (count_reg != '0);
    assign out_item   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + QPTR_W'(1);
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `DSCE_ASSERT_NOW(a_full_stalls_front, count_reg == QCNT_W'(QUEUE_DEPTH), !push_ready)
    `DSCE_ASSERT_NEXT(a_count_tracks_push, do_push && !do_pop, count_reg == $past(count_reg) + QCNT_W'(1))
    `DSCE_ASSERT_NEXT(a_count_tracks_pop, do_pop && !do_push, count_reg == $past(count_reg) - QCNT_W'(1))
    `DSCE_ASSERT_NOW(a_no_empty_item, out_valid, out_item.byte_valid || out_item.done_res)

endmodule

FILE: sv/der_sequence_content_extractor.sv
// DER SEQUENCE content extractor.
// Input channel (in_valid/in_ready): one byte of the encoding per item in
// data_byte, last_byte set on the final byte. Output channel
// (out_valid/out_ready): one item per content byte passed on (byte_valid=1)
// and one for the final byte (done_res=1, with status and out_count); a byte
// can give both at once; header and tag bytes other than the final byte give none.
// Throughput: one input item per cycle while the queue is not full. The parser
// updates its phase in the accepting cycle and writes the result into a two-entry
// queue; the output shows the item read from the queue memory.
// When the receiver stalls, the queue absorbs up to two results; in_ready
// drops only while the queue is full.
// APB port: register 0 strip_enable (addr 0x0), register 1 strip_length
// (addr 0x4); write only while the block is idle. pready is tied high.
// Reset (rst_n low, async) returns the parser to expecting the outer tag,
// empties the queue, and sets strip_enable=1, strip_length=33.
module der_sequence_content_extractor
    import dsce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic        done_res,
    output logic [2:0]  status,
    output logic [23:0] out_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic        strip_enable_reg;
    logic [7:0]  strip_length_reg;
    logic        cfg_write;
    logic        push_valid;
    logic        push_ready;
    result_t     push_item;
    result_t     out_item;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strip_enable_reg <= STRIP_ENABLE_RST[0];
            strip_length_reg <= STRIP_LENGTH_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_STRIP_ENABLE: strip_enable_reg <= pwdata[0];
                REG_STRIP_LENGTH: strip_length_reg <= pwdata[7:0];
                default:          strip_enable_reg <= strip_enable_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_STRIP_ENABLE: prdata = {31'd0, strip_enable_reg};
            REG_STRIP_LENGTH: prdata = {24'd0, strip_length_reg};
            default:          prdata = 32'd0;
        endcase
    end

    dsce_parse u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .strip_enable (strip_enable_reg),
        .strip_length (strip_length_reg),
        .push_ready   (push_ready),
        .push_valid   (push_valid),
        .push_item    (push_item)
    );

    dsce_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

    assign out_byte   = out_item.out_byte;
    assign byte_valid = out_item.byte_valid;
    assign done_res   = out_item.done_res;
    assign status     = out_item.status;
    assign out_count  = out_item.out_count;

endmodule

FILE: tb/tb_top.sv
module tb_top;
    import dsce_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    typedef enum int {
        F_GOOD,
        F_BAD_TAG,
        F_BAD_FORM,
        F_SHORT_BODY,
        F_LONG_BODY,
        F_CUT_HEADER,
        F_CUT_ELEMENT,
        F_NOISE
    } frame_kind_t;

    // Tracks the parser state and holds the results that are still owed.
    class content_scoreboard;
        bit              strip_en;
        bit [7:0]        strip_len;
        phase_t          ph;
        bit [LBL_W-1:0]  len_left;
        bit [23:0]       decl_len;
        bit [24:0]       seen;
        bit [7:0]        elem_left;
        bit              strip_pend;
        bit [23:0]       produced;
        status_t         err;
        result_t         pending_results[$];
        int              fails;
        int              checked;
        int              status_hits[8];

        function new();
            strip_en  = STRIP_ENABLE_RST[0];
            strip_len = STRIP_LENGTH_RST;
            clear();
        endfunction

        function void clear();
            ph         = PH_OUTER_TAG;
            len_left   = '0;
            decl_len   = '0;
            seen       = '0;
            elem_left  = '0;
            strip_pend = 1'b0;
            produced   = '0;
            err        = ST_OK;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void note_byte(logic [7:0] b, logic l);
            result_t   r;
            bit        emit;
            status_t   st;
            bit [23:0] cnt;
            emit = 1'b0;
            st   = ST_OK;
            cnt  = '0;
            if (err == ST_OK)
            begin
                if (ph >= PH_ELEM_TAG && seen <= MAX24)
                    seen++;
                case (ph)
                    PH_OUTER_TAG:
                        if (b != SEQ_TAG)
                            err = ST_BAD_TAG;
                        else
                            ph = PH_OUTER_LEN;
                    PH_OUTER_LEN:
                        if (!b[7])
                        begin
                            decl_len = {16'h0, b};
                            ph = PH_ELEM_TAG;
                        end
                        else if (b[6:0] == 0 || b[6:0] > MAX_LENGTH_BYTES)
                            err = ST_BAD_FORM;
                        else
                        begin
                            len_left = b[LBL_W-1:0];
                            decl_len = '0;
                            ph = PH_LONG_LEN;
                        end
                    PH_LONG_LEN:
                        if (decl_len > (MAX24 >> 8))
                            err = ST_BAD_FORM;
                        else
                        begin
                            decl_len = {decl_len[15:0], b};
                            len_left = len_left - 1'b1;
                            if (len_left == 0)
                                ph = PH_ELEM_TAG;
                        end
                    PH_ELEM_TAG:
                        ph = PH_ELEM_LEN;
                    PH_ELEM_LEN:
                    begin
                        elem_left  = b;
                        strip_pend = strip_en && b == strip_len && b != 0;
                        ph = (b == 0) ? PH_ELEM_TAG : PH_ELEM_DATA;
                    end
                    default:
                    begin
                        // a zero first byte of a strip-length element is dropped
                        if (!(strip_pend && b == 0))
                        begin
                            emit = 1'b1;
                            if (produced < MAX24)
                                produced++;
                        end
                        strip_pend = 1'b0;
                        elem_left--;
                        if (elem_left == 0)
                            ph = PH_ELEM_TAG;
                    end
                endcase
            end
            if (l)
            begin
                if (err != ST_OK)
                    st = err;
                else if (ph <= PH_LONG_LEN)
                    st = ST_MISMATCH;
                else if (seen != {1'b0, decl_len})
                    st = ST_MISMATCH;
                else if (ph != PH_ELEM_TAG)
                    st = ST_TRUNCATED;
                cnt = produced;
                clear();
            end
            if (emit || l)
            begin
                r.out_byte   = emit ? b : 8'h00;
                r.byte_valid = emit;
                r.done_res   = l;
                r.status     = st;
                r.out_count  = cnt;
                pending_results.push_back(r);
            end
        endfunction

        task report(string what, int unsigned got_v, int unsigned want_v);
            fails++;
            $display("mismatch: %s got %0h expected %0h at result %0d",
                     what, got_v, want_v, checked);
        endtask

        task check_result(result_t got);
            result_t want;
            checked++;
            if (pending_results.size() == 0)
            begin
                report("result with nothing pending, out_byte", got.out_byte, 0);
                return;
            end
            want = pending_results.pop_front();
            if (got.out_byte !== want.out_byte)
                report("out_byte", got.out_byte, want.out_byte);
            if (got.byte_valid !== want.byte_valid)
                report("byte_valid", got.byte_valid, want.byte_valid);
            if (got.done_res !== want.done_res)
                report("done_res", got.done_res, want.done_res);
            if (got.status !== want.status)
                report("status", got.status, want.status);
            if (got.out_count !== want.out_count)
                report("out_count", got.out_count, want.out_count);
            if (want.done_res)
                status_hits[want.status]++;
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        done_res;
    logic [2:0]  status;
    logic [23:0] out_count;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    content_scoreboard sb = new();
    result_t           got_res;
    logic [7:0]        frame_q[$];
    logic [7:0]        body_q[$];
    int                items_sent = 0;
    int unsigned       cycle_count = 0;
    bit                steady = 1'b0;
    bit                hold_out = 1'b0;

    der_sequence_content_extractor dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results still pending",
                 cycle_count, sb.pending());
        $display("tb: failure");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off when asked.
    initial
    begin : result_side
        int stall_left;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_out)
            begin
                out_ready <= 1'b0;
                for (stall_left = HOLD_CYCLES; stall_left > 0; stall_left--)
                    @(posedge clk);
                hold_out = 1'b0;
            end
            out_ready <= steady || ($urandom_range(99) >= 38);
        end
    end

    always @(posedge clk)
    begin : result_monitor
        if (rst_n && out_valid && out_ready)
        begin
            got_res.out_byte   = out_byte;
            got_res.byte_valid = byte_valid;
            got_res.done_res   = done_res;
            got_res.status     = status_t'(status);
            got_res.out_count  = out_count;
            sb.check_result(got_res);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic l);
        while (!steady && $urandom_range(99) < 38)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_byte(b, l);
        items_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++)
            send_byte(frame_q[i], i == frame_q.size() - 1);
    endtask

    // Lower valid, wait for every owed result, then let the pipe settle.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_STRIP_ENABLE)
            sb.strip_en = val[0];
        else
            sb.strip_len = val[7:0];
        @(posedge clk);
    endtask

    // Random elements: tag, one-byte length, content. Strip-length elements
    // and zero-length elements show up often; first content byte is often 0.
    function automatic void make_body(int n_elem, bit allow_long);
        int e, k, len, pick;
        body_q.delete();
        for (e = 0; e < n_elem; e++)
        begin
            pick = $urandom_range(9);
            if (pick < 3 && sb.strip_len != 0 && (allow_long || sb.strip_len <= 40))
                len = sb.strip_len;
            else if (pick == 3)
                len = 0;
            else
                len = $urandom_range(12, 1);
            body_q.push_back(8'($urandom));
            body_q.push_back(8'(len));
            for (k = 0; k < len; k++)
                body_q.push_back((k == 0 && $urandom_range(1) == 1) ? 8'h00 : 8'($urandom));
        end
    endfunction

    // Outer tag, length in short or padded long form, then the body.
    function automatic void frame_with_header(int declared);
        int nb, k;
        frame_q.push_back(SEQ_TAG);
        if (declared < 128 && $urandom_range(3) != 0)
            frame_q.push_back(8'(declared));
        else
        begin
            nb = (declared < 256) ? 1 : (declared < 65536) ? 2 : 3;
            nb = $urandom_range(MAX_LENGTH_BYTES, nb);
            frame_q.push_back(8'h80 | 8'(nb));
            for (k = nb - 1; k >= 0; k--)
                frame_q.push_back(8'(declared >> (8 * k)));
        end
        foreach (body_q[i])
            frame_q.push_back(body_q[i]);
    endfunction

    function automatic void build_frame(frame_kind_t kind, bit allow_long);
        int k, nb, p, len;
        logic [7:0] b;
        frame_q.delete();
        case (kind)
            F_GOOD:
            begin
                make_body(allow_long ? $urandom_range(2, 1) : $urandom_range(4, 0), allow_long);
                frame_with_header(body_q.size());
            end
            F_SHORT_BODY:
            begin
                make_body($urandom_range(3, 0), 1'b0);
                if ($urandom_range(3) == 0)
                    frame_with_header($urandom_range(24'hFF_FFFF, 65536));
                else
                    frame_with_header(body_q.size() + $urandom_range(5, 1));
            end
            F_LONG_BODY:
            begin
                make_body($urandom_range(3, 1), 1'b0);
                frame_with_header(body_q.size() - $urandom_range(body_q.size(), 1));
            end
            F_CUT_ELEMENT:
            begin
                // declared length matches, but the last element stops early
                make_body($urandom_range(3, 0), 1'b0);
                len = $urandom_range(12, 2);
                body_q.push_back(8'($urandom));
                if ($urandom_range(3) != 0)
                begin
                    body_q.push_back(8'(len));
                    p = $urandom_range(len - 1, 0);
                    for (k = 0; k < p; k++)
                        body_q.push_back(8'($urandom));
                end
                frame_with_header(body_q.size());
            end
            F_CUT_HEADER:
            begin
                frame_q.push_back(SEQ_TAG);
                if ($urandom_range(1) == 1)
                begin
                    nb = $urandom_range(MAX_LENGTH_BYTES, 1);
                    frame_q.push_back(8'h80 | 8'(nb));
                    p = $urandom_range(nb - 1, 0);
                    for (k = 0; k < p; k++)
                        frame_q.push_back(8'($urandom));
                end
            end
            F_BAD_TAG:
            begin
                b = 8'($urandom);
                frame_q.push_back(b == SEQ_TAG ? ~b : b);
                p = $urandom_range(6, 0);
                for (k = 0; k < p; k++)
                    frame_q.push_back(8'($urandom));
            end
            F_BAD_FORM:
            begin
                frame_q.push_back(SEQ_TAG);
                frame_q.push_back($urandom_range(1) == 1 ? 8'h80 :
                                  8'($urandom_range(255, 8'h81 + MAX_LENGTH_BYTES)));
                p = $urandom_range(6, 0);
                for (k = 0; k < p; k++)
                    frame_q.push_back(8'($urandom));
            end
            default:
            begin
                p = $urandom_range(8, 1);
                for (k = 0; k < p; k++)
                    frame_q.push_back(8'($urandom));
            end
        endcase
    endfunction

    task automatic run_phase(input int target, input int long_frames);
        int goal, nf, pick;
        frame_kind_t kind;
        goal = items_sent + target;
        nf = 0;
        while (items_sent < goal)
        begin
            pick = $urandom_range(99);
            kind = pick < 58 ? F_GOOD : pick < 64 ? F_BAD_TAG : pick < 70 ? F_BAD_FORM :
                   pick < 77 ? F_SHORT_BODY : pick < 83 ? F_LONG_BODY :
                   pick < 87 ? F_CUT_HEADER : pick < 95 ? F_CUT_ELEMENT : F_NOISE;
            if (nf < long_frames)
                kind = F_GOOD;
            build_frame(kind, nf < long_frames);
            send_frame();
            nf++;
        end
        drain();
    endtask

    initial
    begin : stimulus
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        data_byte <= '0;
        last_byte <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty sequence, single wrong tag, indefinite and too-wide length forms
        frame_q = {SEQ_TAG, 8'h00};
        send_frame();
        frame_q = {8'h31};
        send_frame();
        frame_q = {SEQ_TAG, 8'h80};
        send_frame();
        frame_q = {SEQ_TAG, 8'h84, 8'hAA};
        send_frame();
        // long form length, element holding 0x00 and 0xFF
        frame_q = {SEQ_TAG, 8'h81, 8'h04, 8'h02, 8'h02, 8'h00, 8'hFF};
        send_frame();
        // zero-length element, then a tag on the final byte
        frame_q = {SEQ_TAG, 8'h03, 8'h05, 8'h00, 8'h04};
        send_frame();
        // header cut short, then too few bytes for the length
        frame_q = {SEQ_TAG};
        send_frame();
        frame_q = {SEQ_TAG, 8'h02, 8'h01};
        send_frame();
        drain();

        // reset settings; receiver holds off long enough to back up the input
        hold_out = 1'b1;
        run_phase(400, 0);

        write_reg(REG_STRIP_ENABLE, 32'd0);
        write_reg(REG_STRIP_LENGTH, {24'h0, STRIP_LENGTH_RST});
        steady = 1'b1;
        run_phase(200, 0);
        steady = 1'b0;

        write_reg(REG_STRIP_ENABLE, 32'd1);
        write_reg(REG_STRIP_LENGTH, 32'd0);
        run_phase(200, 0);

        write_reg(REG_STRIP_LENGTH, 32'd255);
        run_phase(250, 2);

        write_reg(REG_STRIP_LENGTH, 32'($urandom_range(6, 1)));
        run_phase(300, 0);

        repeat (8) @(posedge clk);
        $display("summary: %0d bytes in, %0d results checked, %0d cycles",
                 items_sent, sb.checked, cycle_count);
        $display("summary: ends ok %0d, bad tag %0d, mismatch %0d, bad form %0d, truncated %0d",
                 sb.status_hits[ST_OK], sb.status_hits[ST_BAD_TAG],
                 sb.status_hits[ST_MISMATCH], sb.status_hits[ST_BAD_FORM],
                 sb.status_hits[ST_TRUNCATED]);
        if (sb.fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
